// ===== rtl/pfa_pkg.sv =====
// pfa_pkg: shared constants, codes and controller/datapath interface structs
// for the page frame allocator; no dependencies
package pfa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 64;
  localparam int PAGE_W     = 12;                 // page number bits
  localparam int CNT_W      = 13;                 // page count bits
  localparam int WORD_W     = 64;                 // map bits per row
  localparam int BIT_W      = 6;                  // bit index within a row
  localparam int ROWS       = MAX_PAGES / WORD_W;
  localparam int ROW_W      = PAGE_W - BIT_W;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic                load;       // capture request fields
    logic                scan_init;  // set up next-fit scan from hint
    logic                free_init;  // point at the page being freed
    logic                rd;         // read current map row
    logic                adv;        // step scan to next row
    logic                mark;       // set found bit, move hint
    logic                unmark;     // clear bit of freed page
    logic                init;       // clear map, reserve map page when full
    logic                addr;       // form result address
    logic                set_res;    // load result status
    logic [STATUS_W-1:0] res_code;
  } pfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             n_zero;     // no active pages
    logic             below;      // free address under region
    logic             beyond;     // free address past active pages
    logic             found;      // free page in current row
    logic             scan_end;   // current row is the last of the scan
    logic             bit_set;    // freed page is marked
  } pfa_sts_t;

endpackage

// ===== rtl/pfa_ctrl.sv =====
// pfa_ctrl: request sequencer of the page frame allocator
// depends on pfa_pkg; drives pfa_dpath through pfa_cmd_t
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  pfa_pkg::pfa_sts_t sts,
  output logic              in_ready,
  output logic              out_load,
  output pfa_pkg::pfa_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RD     = 6'b000100,
    S_CHK    = 6'b001000,
    S_ADDR   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_code = pfa_pkg::ST_OK;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.req)
          pfa_pkg::REQ_ALLOC: begin
            if (sts.n_zero) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = pfa_pkg::ST_OOM;
              state_next   = S_RESULT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_RD;
            end
          end
          pfa_pkg::REQ_FREE: begin
            if (sts.below) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = pfa_pkg::ST_BELOW;
              state_next   = S_RESULT;
            end else if (sts.beyond) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = pfa_pkg::ST_BEYOND;
              state_next   = S_RESULT;
            end else begin
              cmd.free_init = 1'b1;
              state_next    = S_RD;
            end
          end
          pfa_pkg::REQ_INIT: begin
            cmd.init     = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = pfa_pkg::ST_OK;
            state_next   = S_RESULT;
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = pfa_pkg::ST_OK;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.req == pfa_pkg::REQ_FREE) begin
          cmd.set_res = 1'b1;
          if (sts.bit_set) begin
            cmd.unmark   = 1'b1;
            cmd.res_code = pfa_pkg::ST_OK;
          end else begin
            cmd.res_code = pfa_pkg::ST_NOT_ALLOC;
          end
          state_next = S_RESULT;
        end else if (sts.found) begin
          cmd.mark   = 1'b1;
          state_next = S_ADDR;
        end else if (sts.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = pfa_pkg::ST_OOM;
          state_next   = S_RESULT;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_ADDR: begin
        cmd.addr     = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = pfa_pkg::ST_OK;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pfa_dpath.sv =====
// pfa_dpath: configuration registers, page map memory, hint and scan datapath
// depends on pfa_pkg; commanded by pfa_ctrl
module pfa_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]        cfg_data,
  input  logic [pfa_pkg::REQ_W-1:0]         req_type,
  input  logic [pfa_pkg::ADDR_W-1:0]        free_addr,
  input  pfa_pkg::pfa_cmd_t                 cmd,
  output pfa_pkg::pfa_sts_t                 sts,
  output logic [pfa_pkg::STATUS_W-1:0]      res_status,
  output logic [pfa_pkg::ADDR_W-1:0]        res_addr
);

  localparam logic [pfa_pkg::WORD_W-1:0] ONES = '1;

  // configuration
  logic [pfa_pkg::ADDR_W-1:0] region_base;
  logic [pfa_pkg::CNT_W-1:0]  page_count;

  // captured request
  logic [pfa_pkg::REQ_W-1:0]  req;
  logic [pfa_pkg::ADDR_W-1:0] in_addr;

  // map storage, one valid bit per row so reset and init clear at once
  logic [pfa_pkg::WORD_W-1:0] mem [pfa_pkg::ROWS];
  logic [pfa_pkg::ROWS-1:0]   row_vld;
  logic [pfa_pkg::WORD_W-1:0] rd_word;
  logic                       rd_vld;

  logic [pfa_pkg::PAGE_W-1:0] next_hint;

  // scan state
  logic [pfa_pkg::ROW_W-1:0]  cur_row;
  logic [pfa_pkg::ROW_W-1:0]  st_row;
  logic [pfa_pkg::BIT_W-1:0]  st_bit;
  logic [pfa_pkg::ROW_W-1:0]  last_row;
  logic                       phase_b;
  logic [pfa_pkg::PAGE_W-1:0] page;

  logic [pfa_pkg::CNT_W-1:0]  n_act;
  logic [pfa_pkg::CNT_W-1:0]  n_m1;
  logic                       full;
  logic [pfa_pkg::PAGE_W-1:0] start;
  logic [pfa_pkg::ADDR_W-1:0] diff;
  logic [pfa_pkg::WORD_W-1:0] rd_eff;
  logic [pfa_pkg::WORD_W-1:0] lim_mask;
  logic [pfa_pkg::WORD_W-1:0] head_mask;
  logic [pfa_pkg::WORD_W-1:0] tail_mask;
  logic [pfa_pkg::WORD_W-1:0] cand;
  logic [pfa_pkg::WORD_W-1:0] iso;
  logic [pfa_pkg::BIT_W-1:0]  idx;
  logic                       wr_en;
  logic [pfa_pkg::ROW_W-1:0]  wr_row;
  logic [pfa_pkg::WORD_W-1:0] wr_data;

  // active page count saturates at the map size
  assign n_act = (page_count > pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES))
               ? pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES) : page_count;
  assign n_m1  = n_act - pfa_pkg::CNT_W'(1);
  assign full  = (n_act == pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES));
  assign start = ({1'b0, next_hint} < n_act) ? next_hint : '0;

  assign diff  = in_addr - region_base;

  assign rd_eff = rd_vld ? rd_word : '0;

  // allowed bits of the current row
  assign lim_mask  = ((cur_row == last_row) && (n_act[pfa_pkg::BIT_W-1:0] != '0))
                   ? ~(ONES << n_act[pfa_pkg::BIT_W-1:0]) : ONES;
  assign head_mask = (!phase_b && (cur_row == st_row)) ? (ONES << st_bit) : ONES;
  assign tail_mask = (phase_b && (cur_row == st_row)) ? ~(ONES << st_bit) : ONES;
  assign cand      = ~rd_eff & lim_mask & head_mask & tail_mask;
  assign iso       = cand & (~cand + pfa_pkg::WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < pfa_pkg::WORD_W; i++) begin
      if (iso[i]) begin
        idx = idx | pfa_pkg::BIT_W'(i);
      end
    end
  end

  always_comb begin
    sts.req      = req;
    sts.n_zero   = (n_act == '0);
    sts.below    = (in_addr < region_base);
    sts.beyond   = (diff[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT]
                    >= (pfa_pkg::ADDR_W-pfa_pkg::PAGE_SHIFT)'(n_act));
    sts.found    = (cand != '0);
    sts.scan_end = phase_b && (cur_row == st_row);
    sts.bit_set  = rd_eff[page[pfa_pkg::BIT_W-1:0]];
  end

  // map write port
  always_comb begin
    wr_en   = 1'b0;
    wr_row  = cur_row;
    wr_data = rd_eff | iso;
    if (cmd.init && full) begin
      wr_en   = 1'b1;
      wr_row  = '0;
      wr_data = pfa_pkg::WORD_W'(1);
    end else if (cmd.mark) begin
      wr_en = 1'b1;
    end else if (cmd.unmark) begin
      wr_en   = 1'b1;
      wr_data = rd_eff & ~(pfa_pkg::WORD_W'(1) << page[pfa_pkg::BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (cmd.rd) begin
      rd_word <= mem[cur_row];
      rd_vld  <= row_vld[cur_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.init) begin
      // only row zero stays live, and only when it holds the map page
      row_vld <= pfa_pkg::ROWS'(full);
    end else if (wr_en) begin
      row_vld[wr_row] <= 1'b1;
    end
  end

  // configuration and hint
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_count  <= '0;
      next_hint   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfa_pkg::CFG_REGION_BASE: region_base <= cfg_data;
          pfa_pkg::CFG_PAGE_COUNT:  page_count  <= cfg_data[pfa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.mark) begin
        next_hint <= {cur_row, idx};
      end else if (cmd.init && full) begin
        next_hint <= '0;
      end
    end
  end

  // request capture, scan pointers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= req_type;
      in_addr  <= free_addr;
      res_addr <= '1;
    end
    if (cmd.scan_init) begin
      cur_row  <= start[pfa_pkg::PAGE_W-1:pfa_pkg::BIT_W];
      st_row   <= start[pfa_pkg::PAGE_W-1:pfa_pkg::BIT_W];
      st_bit   <= start[pfa_pkg::BIT_W-1:0];
      last_row <= n_m1[pfa_pkg::PAGE_W-1:pfa_pkg::BIT_W];
      phase_b  <= 1'b0;
    end
    if (cmd.free_init) begin
      page     <= diff[pfa_pkg::PAGE_SHIFT +: pfa_pkg::PAGE_W];
      cur_row  <= diff[pfa_pkg::PAGE_SHIFT+pfa_pkg::BIT_W +: pfa_pkg::ROW_W];
      last_row <= n_m1[pfa_pkg::PAGE_W-1:pfa_pkg::BIT_W];
    end
    if (cmd.adv) begin
      if (!phase_b && (cur_row == last_row)) begin
        phase_b <= 1'b1;
        cur_row <= '0;
      end else begin
        cur_row <= cur_row + pfa_pkg::ROW_W'(1);
      end
    end
    if (cmd.mark) begin
      page <= {cur_row, idx};
    end
    if (cmd.addr) begin
      res_addr <= region_base
                + {{(pfa_pkg::ADDR_W-pfa_pkg::PAGE_W-pfa_pkg::PAGE_SHIFT){1'b0}},
                   page, {pfa_pkg::PAGE_SHIFT{1'b0}}};
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
    end
  end

`ifndef SYNTHESIS
  a_mark_found: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> sts.found)
    else $error("page marked without a free candidate");

  a_unmark_set: assert property (@(posedge clk) disable iff (rst)
    cmd.unmark |-> sts.bit_set)
    else $error("freeing a page that is not marked");

  a_init_map: assert property (@(posedge clk) disable iff (rst)
    (cmd.init && full) |=> (row_vld == pfa_pkg::ROWS'(1)))
    else $error("init left rows other than row zero live");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (cur_row <= last_row))
    else $error("map read past last active row");
`endif

endmodule

// ===== rtl/page_frame_allocator_core.sv =====
// page_frame_allocator_core: top level, stream ports, config port, output register
// depends on pfa_pkg, pfa_ctrl and pfa_dpath
// path to result valid: init, rejected free, unused codes and an empty region go
//   decode then result; free reads and checks its map row; allocate reads and checks
//   each map row visited (64 pages a row, at most 65 rows visited), then forms the
//   address or reports out of memory; one request in flight, the next taken in the
//   cycle after the result is registered; map row read and check set the scan pace
// reset clears map row valid bits, hint, config and control at once; no sweep
module page_frame_allocator_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [1:0] req_type, [65:2] free_addr, rest zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // [2:0] status, [66:3] page_addr, rest zero
);

  pfa_pkg::pfa_cmd_t                cmd;
  pfa_pkg::pfa_sts_t                sts;
  logic                             out_load;
  logic                             out_free;
  logic [pfa_pkg::STATUS_W-1:0]     res_status;
  logic [pfa_pkg::ADDR_W-1:0]       res_addr;

  // output register can take a result when empty or draining this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  pfa_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (s_axis_tdata[pfa_pkg::REQ_W-1:0]),
    .free_addr  (s_axis_tdata[pfa_pkg::REQ_W +: pfa_pkg::ADDR_W]),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (res_status),
    .res_addr   (res_addr)
  );

  // result register, holds a finished transaction while the next request runs
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'b0, res_addr, res_status};
    end
  end

endmodule

// ===== test/page_frame_allocator_core_checker.sv =====
// page_frame_allocator_core_checker: watches the config port and both streams,
// keeps its own page map, hint and region registers, and scores every result
// depends on pfa_pkg for widths, request and status codes, register indexes
module page_frame_allocator_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  output int          fail_count,
  output int          open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pfa_pkg::STATUS_W-1:0] status;
    logic [pfa_pkg::ADDR_W-1:0]   page_addr;
  } frame_reply_t;

  logic                        frame_used [pfa_pkg::MAX_PAGES];
  logic [pfa_pkg::PAGE_W-1:0]  hint;
  logic [pfa_pkg::ADDR_W-1:0]  base;
  logic [pfa_pkg::CNT_W-1:0]   count;
  frame_reply_t                replies_owed [$];
  int                          mismatches = 0;
  int                          result_no  = 0;

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  // applies one request to the local map and returns the reply it earns
  function automatic frame_reply_t serve_request(
      input logic [pfa_pkg::REQ_W-1:0]  req,
      input logic [pfa_pkg::ADDR_W-1:0] addr);
    int unsigned                n;
    int unsigned                start;
    int unsigned                p;
    int unsigned                i;
    bit                         hit;
    logic [63:0]                off;
    logic [pfa_pkg::PAGE_W-1:0] pg;
    frame_reply_t               r;
    n = (count > pfa_pkg::MAX_PAGES) ? pfa_pkg::MAX_PAGES : count;
    r.status    = pfa_pkg::ST_OK;
    r.page_addr = '1;
    hit = 1'b0;
    case (req)
      pfa_pkg::REQ_ALLOC: begin
        r.status = pfa_pkg::ST_OOM;
        start = (hint < n) ? hint : 0;
        for (i = 0; i < n && !hit; i++) begin
          p = start + i;
          if (p >= n) p = p - n;
          if (!frame_used[p]) begin
            frame_used[p] = 1'b1;
            hint          = p[pfa_pkg::PAGE_W-1:0];
            r.status      = pfa_pkg::ST_OK;
            r.page_addr   = base + (64'(p) << pfa_pkg::PAGE_SHIFT);
            hit           = 1'b1;
          end
        end
      end
      pfa_pkg::REQ_FREE: begin
        off = addr - base;
        pg  = off[pfa_pkg::PAGE_SHIFT +: pfa_pkg::PAGE_W];
        if (addr < base) r.status = pfa_pkg::ST_BELOW;
        else if ((off >> pfa_pkg::PAGE_SHIFT) >= 64'(n)) r.status = pfa_pkg::ST_BEYOND;
        else if (!frame_used[pg]) r.status = pfa_pkg::ST_NOT_ALLOC;
        else frame_used[pg] = 1'b0;
      end
      pfa_pkg::REQ_INIT: begin
        for (i = 0; i < pfa_pkg::MAX_PAGES; i++) frame_used[i] = 1'b0;
        // the map only fills a whole page once every page is active
        if ((n >> pfa_pkg::PAGE_SHIFT) != 0) begin
          frame_used[0] = 1'b1;
          hint          = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    frame_reply_t want;
    frame_reply_t got;
    if (rst) begin
      for (int k = 0; k < pfa_pkg::MAX_PAGES; k++) frame_used[k] = 1'b0;
      hint  = '0;
      base  = '0;
      count = '0;
      replies_owed.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfa_pkg::CFG_REGION_BASE: base  = cfg_data;
          pfa_pkg::CFG_PAGE_COUNT:  count = cfg_data[pfa_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_owed.push_back(serve_request(s_axis_tdata[1:0], s_axis_tdata[65:2]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tdata[2:0];
        got.page_addr = m_axis_tdata[66:3];
        result_no++;
        if (replies_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: status %0d addr %h",
                     result_no, got.status, got.page_addr);
        end else begin
          want = replies_owed.pop_front();
          if (got.status !== want.status || got.page_addr !== want.page_addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected status %0d addr %h, got status %0d addr %h",
                       result_no, want.status, want.page_addr, got.status, got.page_addr);
          end
        end
      end
    end
    open_count <= replies_owed.size();
    fail_count <= mismatches;
  end

endmodule

// ===== test/page_frame_allocator_core_tb.sv =====
// page_frame_allocator_core_tb: drives requests and region settings into the
// allocator, with the checker beside it, and prints the verdict
// depends on pfa_pkg, page_frame_allocator_core and page_frame_allocator_core_checker
module page_frame_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block treats as a no-op
  localparam logic [pfa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // quiet cycles allowed; well above the longest allocate scan
  localparam int WATCHDOG_LIMIT = 4000;
  // cycles to wait after the last result, above the worst scan latency
  localparam int TAIL_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // [1:0] req_type, [65:2] free_addr, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [2:0] status, [66:3] page_addr, rest zero

  int          fail_count;
  int          open_count;
  int          quiet_cycles = 0;
  logic        idle_on = 1'b1;     // random idling on both sides when set

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;

  page_frame_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  page_frame_allocator_core_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .open_count    (open_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: ready drops about 14 percent of the time while idling is on
  always @(posedge clk) begin
    m_axis_tready <= !rst && (!idle_on || $urandom_range(99) >= 14);
  end

  // watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if (rst || s_fire || m_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("page_frame_allocator_core: mismatch");
      $finish;
    end
  end

  // offers one request and holds it until the transaction completes;
  // valid is only dropped when a gap is taken, so it never toggles in one step
  task automatic send_req(input logic [pfa_pkg::REQ_W-1:0] req, input logic [63:0] addr);
    while (idle_on && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, addr, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // waits until every outstanding result is back and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes both region registers on back-to-back cycles, block idle
  task automatic set_region(input logic [63:0] region, input logic [63:0] count_word);
    cfg_we    <= 1'b1;
    cfg_index <= pfa_pkg::CFG_REGION_BASE;
    cfg_data  <= region;
    @(posedge clk);
    cfg_index <= pfa_pkg::CFG_PAGE_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // free addresses: mostly inside the active pages, plus the edges around them
  function automatic logic [63:0] pick_free_addr(input logic [63:0] region,
                                                 input int unsigned pages);
    int unsigned sel;
    logic [63:0] a;
    sel = $urandom_range(99);
    if (sel < 60 && pages != 0)
      a = region + (64'($urandom_range(pages - 1)) << pfa_pkg::PAGE_SHIFT)
                 + 64'($urandom_range(4095));
    else if (sel < 72)
      a = region + (64'(pages + $urandom_range(3)) << pfa_pkg::PAGE_SHIFT)
                 + 64'($urandom_range(4095));
    else if (sel < 84)
      a = region - 64'($urandom_range(8192, 1));
    else if (sel < 92)
      a = region + (64'(pages) << pfa_pkg::PAGE_SHIFT) - 64'd1;   // last active byte, or below an empty region
    else
      a = {$urandom(), $urandom()};
    return a;
  endfunction

  // one setting of the region, then a random mix weighted toward allocate/free
  task automatic run_phase(input logic [63:0] region, input logic [63:0] count_word,
                           input int items, input bit start_init);
    int unsigned pages;
    int unsigned pick;
    int          k;
    drain();
    set_region(region, count_word);
    pages = (count_word[pfa_pkg::CNT_W-1:0] > pfa_pkg::MAX_PAGES)
          ? pfa_pkg::MAX_PAGES : count_word[pfa_pkg::CNT_W-1:0];
    if (start_init) send_req(pfa_pkg::REQ_INIT, {$urandom(), $urandom()});
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) send_req(pfa_pkg::REQ_ALLOC, {$urandom(), $urandom()});
      else if (pick < 90) send_req(pfa_pkg::REQ_FREE, pick_free_addr(region, pages));
      else if (pick < 95) send_req(pfa_pkg::REQ_INIT, {$urandom(), $urandom()});
      else send_req(REQ_UNUSED, {$urandom(), $urandom()});
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no active pages at all
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);                    // out of memory
    send_req(pfa_pkg::REQ_FREE, 64'd0);                     // beyond an empty region
    send_req(REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(pfa_pkg::REQ_INIT, 64'd0);

    // three pages at the top of the address space, third one wraps to zero
    drain();
    set_region(64'hFFFF_FFFF_FFFF_E000, 64'd3);
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);                    // address wraps past 2^64
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);                    // map full
    send_req(pfa_pkg::REQ_FREE, 64'h10);                    // below region
    send_req(pfa_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_FFFF);   // inside page 1, frees it
    send_req(pfa_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_F800);   // page 1 again, not marked
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);                    // scan wraps round to page 1
    send_req(pfa_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_F000);

    // full map size: init reserves page 0 for the map itself
    drain();
    set_region(64'h1000, 64'd4096);
    send_req(pfa_pkg::REQ_INIT, 64'd0);
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);
    send_req(pfa_pkg::REQ_FREE, 64'h0FFF);                             // below
    send_req(pfa_pkg::REQ_FREE,
             64'h1000 + (64'd4096 << pfa_pkg::PAGE_SHIFT));            // first beyond
    send_req(pfa_pkg::REQ_FREE,
             64'h1000 + (64'd4096 << pfa_pkg::PAGE_SHIFT) - 64'd1);    // last page, not allocated
    send_req(pfa_pkg::REQ_FREE, 64'h1000);                             // map page itself
    send_req(pfa_pkg::REQ_ALLOC, 64'd0);
    send_req(REQ_UNUSED, 64'd0);

    // random phases over a spread of region settings
    run_phase({$urandom(), 20'($urandom_range(1048575)), 12'h000}, 64'd40, 300, 1'b1);
    run_phase({$urandom(), $urandom()}, 64'd4096, 250, 1'b1);
    // small count after a long run leaves the hint past the active pages
    run_phase(64'hFFFF_FFFF_FFFF_F000, 64'd17, 200, 1'b0);
    // long stretch with no idling, count saturates past the map size
    drain();
    idle_on <= 1'b0;
    run_phase(64'd0, {$urandom(), 19'($urandom()), 13'd5000}, 250, 1'b1);
    drain();
    idle_on <= 1'b1;
    run_phase({$urandom(), $urandom()}, 64'd1, 150, 1'b0);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, {$urandom(), 19'($urandom()), 13'h1FFF}, 200, 1'b1);
    run_phase({$urandom(), $urandom()}, 64'($urandom_range(200, 2)), 400, 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("page_frame_allocator_core: match");
    else $display("page_frame_allocator_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_dpath.sv
rtl/page_frame_allocator_core.sv
test/page_frame_allocator_core_checker.sv
test/page_frame_allocator_core_tb.sv
